/* rtl/rge_pkg.sv */
// Shared types, constants and helper functions for the random graph edge generator.
package rge_pkg;

  // Counter and field widths
  localparam int CNT_W   = 11;
  localparam int SEED_W  = 31;
  localparam int DRAW_W  = 14;
  localparam int DENS_W  = 10;
  localparam int VTX_W   = 10;
  localparam int THR_W   = 25;
  localparam int DIST_W  = 29;
  localparam int QUOT_W  = 29;
  localparam int QQ_W    = 15;

  // Job queue depth between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;

  // seed / 7 by reciprocal: q = (seed * DIV7_MUL) >> DIV7_SHIFT, exact for 31-bit seeds
  localparam logic [31:0] DIV7_MUL     = 32'd2454267027;
  localparam int          DIV7_SHIFT   = 34;
  // q / 10000 by reciprocal, exact for q below 2^29
  localparam logic [29:0] DIV10K_MUL   = 30'd879609303;
  localparam int          DIV10K_SHIFT = 43;
  localparam logic [13:0] DRAW_MOD     = 14'd10000;

  // Threshold scales for the two modes
  localparam logic [3:0]  EXP_SCALE    = 4'd10;
  localparam logic [14:0] GEO_SCALE    = 15'd31847;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_VCOUNT  = 3'd1;
  localparam logic [2:0] REG_DENSITY = 3'd2;
  localparam logic [2:0] REG_SEED    = 3'd3;
  localparam logic [2:0] REG_COMPL   = 3'd4;

  // Kind of work handed from front to back
  typedef enum logic [1:0] {
    OP_COORD_X  = 2'd0,
    OP_COORD_Y  = 2'd1,
    OP_PAIR_EXP = 2'd2,
    OP_PAIR_GEO = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic              last;
    logic [SEED_W-1:0] seed;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // seed * 65539 mod 2^31 as a shift-add
  function automatic logic [SEED_W-1:0] lcg_next(input logic [SEED_W-1:0] s);
    lcg_next = s + {s[SEED_W-2:0], 1'b0} + {s[SEED_W-17:0], 16'b0};
  endfunction

endpackage

/* rtl/rge_front.sv */
// Front end: walks the graph phases, advances the seed and issues at most one job per tick.
module rge_front import rge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_restart,
  input  logic              cfg_geo,
  input  logic [CNT_W-1:0]  v_eff,
  input  logic [SEED_W-1:0] start_seed,
  output push_t             push
);

  typedef enum logic [2:0] {
    PH_DONE  = 3'b001,
    PH_COORD = 3'b010,
    PH_PAIR  = 3'b100
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [SEED_W-1:0] seed_r, seed_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;

  // Next phase, counters and issued job for one transfer
  always_comb begin
    logic [SEED_W-1:0] s_adv;
    logic              leave;
    logic [CNT_W-1:0]  col_inc;
    logic [CNT_W-1:0]  row_inc;
    logic [CNT_W-1:0]  row_two;
    s_adv     = lcg_next(seed_r);
    leave     = 1'b0;
    col_inc   = col_r + 1'b1;
    row_inc   = row_r + 1'b1;
    row_two   = row_r + CNT_W'(2);
    phase_nxt = phase_r;
    seed_nxt  = seed_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    push      = '0;
    push.job.row  = row_r;
    push.job.col  = col_r;
    push.job.seed = s_adv;
    if (in_accept) begin
      if (in_restart) begin
        seed_nxt = start_seed;
        row_nxt  = '0;
        col_nxt  = '0;
        if (v_eff < CNT_W'(2)) begin
          phase_nxt = PH_DONE;
        end else if (cfg_geo) begin
          phase_nxt = PH_COORD;
        end else begin
          phase_nxt = PH_PAIR;
          col_nxt   = CNT_W'(1);
        end
      end else begin
        case (phase_r)
          PH_COORD: begin
            if (row_r < v_eff) begin
              seed_nxt   = s_adv;
              push.valid = 1'b1;
              if (col_r == '0) begin
                push.job.op = OP_COORD_X;
                col_nxt     = CNT_W'(1);
              end else begin
                push.job.op = OP_COORD_Y;
                col_nxt     = '0;
                row_nxt     = row_inc;
                leave       = (row_inc >= v_eff);
              end
            end else begin
              leave = 1'b1;
            end
            // coordinates done: start the pair walk
            if (leave) begin
              if (v_eff < CNT_W'(2)) begin
                phase_nxt = PH_DONE;
              end else begin
                phase_nxt = PH_PAIR;
                row_nxt   = '0;
                col_nxt   = CNT_W'(1);
              end
            end
          end
          PH_PAIR: begin
            if (row_r >= v_eff || col_r >= v_eff || col_r <= row_r) begin
              phase_nxt = PH_DONE;
            end else begin
              push.valid = 1'b1;
              if (cfg_geo) begin
                push.job.op = OP_PAIR_GEO;
              end else begin
                push.job.op = OP_PAIR_EXP;
                seed_nxt    = s_adv;
              end
              push.job.last = ({1'b0, row_r} + 12'd2 == {1'b0, v_eff}) &&
                              ({1'b0, col_r} + 12'd1 == {1'b0, v_eff});
              if (col_inc >= v_eff) begin
                row_nxt = row_inc;
                col_nxt = row_two;
                if (row_two >= v_eff) begin
                  phase_nxt = PH_DONE;
                end
              end else begin
                col_nxt = col_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      seed_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      seed_r  <= seed_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

/* rtl/rge_queue.sv */
// Short job queue that decouples the front end from the back-end pipeline.
module rge_queue import rge_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  q_valid,
  output job_t  q_job,
  output logic  full
);

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              wr_en;
  logic              rd_en;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = entry_r[rd_ptr_r];
  assign wr_en   = push.valid && !full;
  assign rd_en   = pop && q_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

/* rtl/rge_back.sv */
// Back end: draw scaling, coordinate store, edge tests and the output register.
module rge_back import rge_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  job_t              q_job,
  output logic              pop,
  input  logic [DENS_W-1:0] density,
  input  logic              complement,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VTX_W-1:0]  out_row_vertex,
  output logic [VTX_W-1:0]  out_col_vertex,
  output logic              out_edge_present,
  output logic              out_last_pair
);

  localparam int AW = $clog2(MAX_VERTICES);

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } tag_t;

  logic              adv;
  logic              take;

  logic              s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, out_valid_r;
  tag_t              s2_tag_r, s3_tag_r, s4_tag_r, s5_tag_r, s6_tag_r;
  logic [QUOT_W-1:0] s2_q_r, s3_q_r;
  logic [QQ_W-1:0]   s3_qq_r;
  logic [DRAW_W-1:0] s4_draw_r;
  logic              s5_edge_r, s6_edge_r;
  logic [DRAW_W-1:0] xa_r, xb_r, ya_r, yb_r;
  logic [27:0]       sqx_r, sqy_r;
  logic [THR_W-1:0]  thr_r;

  logic [DRAW_W-1:0] x_mem [MAX_VERTICES];
  logic [DRAW_W-1:0] y_mem [MAX_VERTICES];

  logic [62:0]       prod7;
  logic [58:0]       prod10k;
  logic [QUOT_W-1:0] rem;
  logic              edge_exp;
  logic signed [14:0] dx, dy;
  logic signed [29:0] dx_sq, dy_sq;
  logic [DIST_W-1:0] dsum;
  logic              edge_final;
  tag_t              q_tag;

  // Whole pipeline moves unless the output holds a stalled result
  assign adv  = !out_valid_r || !out_stall;
  assign take = adv && q_valid;
  assign pop  = take;

  assign q_tag = '{op: q_job.op, row: q_job.row, col: q_job.col, last: q_job.last};

  // Stage arithmetic
  assign prod7    = 63'(q_job.seed) * 63'(DIV7_MUL);
  assign prod10k  = 59'(s2_q_r) * 59'(DIV10K_MUL);
  assign rem      = s3_q_r - QUOT_W'(s3_qq_r) * QUOT_W'(DRAW_MOD);
  assign edge_exp = s4_draw_r < (DRAW_W'(density) * DRAW_W'(EXP_SCALE));
  assign dx       = $signed({1'b0, xa_r}) - $signed({1'b0, xb_r});
  assign dy       = $signed({1'b0, ya_r}) - $signed({1'b0, yb_r});
  assign dx_sq    = dx * dx;
  assign dy_sq    = dy * dy;
  assign dsum     = DIST_W'(sqx_r) + DIST_W'(sqy_r);
  assign edge_final = ((s6_tag_r.op == OP_PAIR_GEO) ? (dsum < DIST_W'(thr_r)) : s6_edge_r)
                      ^ complement;

  // Geometric threshold follows the density register
  always_ff @(posedge clk) begin
    thr_r <= THR_W'(density) * THR_W'(GEO_SCALE);
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_v_r      <= take;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      s5_v_r      <= s4_v_r &&
                     (s4_tag_r.op == OP_PAIR_EXP || s4_tag_r.op == OP_PAIR_GEO);
      s6_v_r      <= s5_v_r;
      out_valid_r <= s6_v_r;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag_r  <= q_tag;
      s2_q_r    <= prod7[62:DIV7_SHIFT];
      s3_tag_r  <= s2_tag_r;
      s3_q_r    <= s2_q_r;
      s3_qq_r   <= prod10k[57:DIV10K_SHIFT];
      s4_tag_r  <= s3_tag_r;
      s4_draw_r <= rem[DRAW_W-1:0];
      s5_tag_r  <= s4_tag_r;
      s5_edge_r <= edge_exp;
      s6_tag_r  <= s5_tag_r;
      s6_edge_r <= s5_edge_r;
      sqx_r     <= dx_sq[27:0];
      sqy_r     <= dy_sq[27:0];
      out_row_vertex   <= s6_tag_r.row[VTX_W-1:0];
      out_col_vertex   <= s6_tag_r.col[VTX_W-1:0];
      out_edge_present <= edge_final;
      out_last_pair    <= s6_tag_r.last;
    end
  end

  // Coordinate stores: written by coordinate jobs, read by geometric pairs
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s4_v_r && s4_tag_r.op == OP_COORD_X) begin
        x_mem[AW'(s4_tag_r.row)] <= s4_draw_r;
      end
      xa_r <= x_mem[AW'(s4_tag_r.row)];
      xb_r <= x_mem[AW'(s4_tag_r.col)];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s4_v_r && s4_tag_r.op == OP_COORD_Y) begin
        y_mem[AW'(s4_tag_r.row)] <= s4_draw_r;
      end
      ya_r <= y_mem[AW'(s4_tag_r.row)];
      yb_r <= y_mem[AW'(s4_tag_r.col)];
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/random_graph_edge_generator.sv */
// Random graph edge generator: one upper-triangle vertex-pair decision per generation tick.
// A transfer with restart set reloads the seed and clears the counters and emits nothing;
// each later tick either draws a vertex coordinate (geometric mode, first 2v ticks, no
// result) or yields one pair with its edge bit, up to the last pair. While in_stall is low,
// ticks are taken one per clock: the front end settles each tick combinationally and
// passes a job through a 4-entry queue to a 6-stage back end (reciprocal scaling of the
// draw, coordinate memory read, squaring), so without stalls the sustained rate is one
// pair per cycle. in_stall rises only when the queue is full, i.e. after out_stall has
// held the back end long enough to fill it. The two coordinate memories
// (MAX_VERTICES x 14 bits) are not cleared; a geometric test on a vertex whose
// coordinates were never drawn returns an undefined bit. The user must write configuration
// over the APB port only while idle; the block does not enforce this.
module random_graph_edge_generator import rge_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_restart,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VTX_W-1:0]  out_row_vertex,
  output logic [VTX_W-1:0]  out_col_vertex,
  output logic              out_edge_present,
  output logic              out_last_pair,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // Saturation limit for the vertex count
  localparam logic [CNT_W:0] MAX_V = (MAX_VERTICES > 2047) ? 12'd2047 : 12'(MAX_VERTICES);

  logic              mode_r;
  logic [CNT_W-1:0]  vcount_r;
  logic [DENS_W-1:0] density_r;
  logic [SEED_W-1:0] seed_cfg_r;
  logic              compl_r;

  logic              cfg_wr;
  logic [2:0]        cfg_idx;
  logic [CNT_W-1:0]  v_eff;
  logic              in_accept;
  push_t             push;
  logic              q_valid;
  job_t              q_job;
  logic              q_pop;
  logic              q_full;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      vcount_r   <= CNT_W'(2);
      density_r  <= '0;
      seed_cfg_r <= SEED_W'(1);
      compl_r    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:    mode_r     <= cfg_pwdata[0];
        REG_VCOUNT:  vcount_r   <= cfg_pwdata[CNT_W-1:0];
        REG_DENSITY: density_r  <= cfg_pwdata[DENS_W-1:0];
        REG_SEED:    seed_cfg_r <= cfg_pwdata[SEED_W-1:0];
        REG_COMPL:   compl_r    <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_MODE:    cfg_prdata = {31'b0, mode_r};
      REG_VCOUNT:  cfg_prdata = 32'(vcount_r);
      REG_DENSITY: cfg_prdata = 32'(density_r);
      REG_SEED:    cfg_prdata = 32'(seed_cfg_r);
      REG_COMPL:   cfg_prdata = {31'b0, compl_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign v_eff     = ({1'b0, vcount_r} > MAX_V) ? MAX_V[CNT_W-1:0] : vcount_r;
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  rge_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_restart (in_restart),
    .cfg_geo    (mode_r),
    .v_eff      (v_eff),
    .start_seed (seed_cfg_r),
    .push       (push)
  );

  rge_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_job   (q_job),
    .full    (q_full)
  );

  rge_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (q_job),
    .pop              (q_pop),
    .density          (density_r),
    .complement       (compl_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row_vertex   (out_row_vertex),
    .out_col_vertex   (out_col_vertex),
    .out_edge_present (out_edge_present),
    .out_last_pair    (out_last_pair)
  );

endmodule

/* rtl/rge_checker.sv */
// Port-level checker for the random graph edge generator, bound to the top level.
module rge_checker import rge_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_restart,
  input logic             out_valid,
  input logic             out_stall,
  input logic [VTX_W-1:0] out_row_vertex,
  input logic [VTX_W-1:0] out_col_vertex,
  input logic             out_edge_present,
  input logic             out_last_pair
);

  logic seen_restart_r;

  // Tracks whether any restart transfer has happened since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_restart_r <= 1'b0;
    end else if (in_valid && !in_stall && in_restart) begin
      seen_restart_r <= 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_vertex) &&
      $stable(out_col_vertex) && $stable(out_edge_present) && $stable(out_last_pair))
    else $error("stalled result changed");

  // No result before the first restart
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_restart_r)
    else $error("result before any restart");

  // The final pair is always two neighboring vertices
  a_last_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pair |-> out_col_vertex == VTX_W'(out_row_vertex + 1'b1))
    else $error("last pair not adjacent");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind random_graph_edge_generator rge_checker u_rge_checker (.*);
